>>> sv/bira_pkg.sv
// bira_pkg: shared constants, opcode and status codes and the command record
// passed from the front end through the queue to the table engine
// depends on nothing
package bira_pkg;

    localparam int MAX_MEMBERS  = 16;
    localparam int BYTES_PER_ID = 64;
    localparam int IDX_W        = $clog2(MAX_MEMBERS);
    localparam int CNT_W        = $clog2(MAX_MEMBERS + 1);
    localparam int MSG_W        = 12;
    localparam int BOARD_W      = 32;
    localparam int SIZE_W       = 16;
    localparam int CEIL_W       = SIZE_W + 1;
    localparam int Q_DEPTH      = 2;
    localparam int QP_W         = $clog2(Q_DEPTH);
    localparam int QC_W         = $clog2(Q_DEPTH + 1);
    localparam logic [MSG_W-1:0] TOTAL_MAX = '1;
    localparam logic [MSG_W-1:0] TOP_RESET = MSG_W'(2048);

    typedef enum logic [2:0] {
        OPC_JOIN     = 3'd0,
        OPC_KICK     = 3'd1,
        OPC_HB_START = 3'd2,
        OPC_REPLY    = 3'd3,
        OPC_HB_END   = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_NO_ROOM   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_KICKED    = 3'd4,
        ST_HEARD     = 3'd5
    } t_status;

    typedef struct packed {
        t_opcode            op;
        logic [BOARD_W-1:0] board;
        logic [MSG_W-1:0]   need;
    } t_cmd;

endpackage

>>> sv/bira_front.sv
// bira_front: accepts input transfers, accumulates join log sizes and
// turns each meaningful item into a command for the queue
// depends on bira_pkg
module bira_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_opcode,
    input  logic [bira_pkg::BOARD_W-1:0]   i_board_id,
    input  logic [bira_pkg::SIZE_W-1:0]    i_log_size,
    input  logic                           i_last_log,
    input  logic                           i_full,
    output logic                           o_push,
    output bira_pkg::t_cmd                 o_cmd
);
    import bira_pkg::*;

    logic                join_en;
    logic [MSG_W-1:0]    r_total;
    logic [MSG_W-1:0]    n_total;
    logic                accept;
    logic [CEIL_W-1:0]   ids;
    logic [CEIL_W:0]     sum;
    logic [MSG_W-1:0]    sat;

    assign busy   = i_full;
    assign accept = start & ~i_full;

    // ids for one log, rounded up, and the saturated running total
    always_comb begin
        ids = CEIL_W'((CEIL_W'(i_log_size) + CEIL_W'(BYTES_PER_ID - 1)) / BYTES_PER_ID);
        sum = (CEIL_W + 1)'(r_total) + (CEIL_W + 1)'(ids);
        sat = (sum > (CEIL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[MSG_W-1:0];
    end

    // classify the transfer into a command
    always_comb begin
        n_total      = r_total;
        o_push       = 1'b0;
        o_cmd.op     = OPC_JOIN;
        o_cmd.board  = i_board_id;
        o_cmd.need   = sat;
        join_en      = 1'b0;
        if (accept) begin
            unique case (i_opcode)
                OPC_JOIN: begin
                    join_en = 1'b1;
                    if (i_last_log) begin
                        o_push  = 1'b1;
                        n_total = '0;
                    end else begin
                        n_total = sat;
                    end
                end
                OPC_KICK: begin
                    o_push   = 1'b1;
                    o_cmd.op = OPC_KICK;
                end
                OPC_HB_START: begin
                    o_push   = 1'b1;
                    o_cmd.op = OPC_HB_START;
                end
                OPC_REPLY: begin
                    o_push   = 1'b1;
                    o_cmd.op = OPC_REPLY;
                end
                OPC_HB_END: begin
                    o_push   = 1'b1;
                    o_cmd.op = OPC_HB_END;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    // running join total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (join_en) begin
            r_total <= n_total;
        end
    end

endmodule

>>> sv/bira_queue.sv
// bira_queue: short command queue between the front end and the table engine
// depends on bira_pkg
module bira_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bira_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output bira_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import bira_pkg::*;

    t_cmd             r_mem [Q_DEPTH];
    logic [QP_W-1:0]  r_wr;
    logic [QP_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == QC_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // command storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/bira_back.sv
// bira_back: member table engine; runs lookups, removals, heartbeat sweeps
// and the best-fit gap search, and drives the result registers
// depends on bira_pkg
module bira_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bira_pkg::MSG_W-1:0]    i_id_space_top,
    input  logic                          i_valid,
    input  bira_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [2:0]                    o_status,
    output logic [bira_pkg::BOARD_W-1:0]  o_result_board,
    output logic [bira_pkg::MSG_W-1:0]    o_range_start,
    output logic [bira_pkg::MSG_W-1:0]    o_range_count,
    output logic                          o_last_result
);
    import bira_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FIND   = 7'b0000010,
        S_REMOVE = 7'b0000100,
        S_SWEEP  = 7'b0001000,
        S_LOAD   = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_PLACE  = 7'b1000000
    } t_state;

    // control
    t_state              r_state, n_state;
    t_state              r_ret, n_ret;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_j, n_j;
    logic [MAX_MEMBERS-1:0] r_heard, n_heard;
    logic                r_found, n_found;
    logic                r_pend_v, n_pend_v;
    logic                r_strobe, n_strobe;

    // payload
    t_cmd                r_cmd, n_cmd;
    logic [BOARD_W-1:0]  r_mid   [MAX_MEMBERS];
    logic [MSG_W-1:0]    r_mstart [MAX_MEMBERS];
    logic [MSG_W-1:0]    r_mend  [MAX_MEMBERS];
    logic [MSG_W-1:0]    r_si, n_si;
    logic [MSG_W-1:0]    r_ei, n_ei;
    logic [MSG_W-1:0]    r_prev, n_prev;
    logic [MSG_W-1:0]    r_emax, n_emax;
    logic [MSG_W-1:0]    r_best, n_best;
    logic [MSG_W-1:0]    r_bstart, n_bstart;
    logic [BOARD_W-1:0]  r_pend_id, n_pend_id;
    t_status             r_status, n_status;
    logic [BOARD_W-1:0]  r_board, n_board;
    logic [MSG_W-1:0]    r_start, n_start;
    logic [MSG_W-1:0]    r_rcount, n_rcount;
    logic                r_last, n_last;

    // table write port
    logic                w_en;
    logic [IDX_W-1:0]    w_addr;
    logic [BOARD_W-1:0]  w_id;
    logic [MSG_W-1:0]    w_start;
    logic [MSG_W-1:0]    w_end;

    // table read port
    logic [IDX_W-1:0]    rd_idx;
    logic [BOARD_W-1:0]  rd_id;
    logic [MSG_W-1:0]    rd_start;
    logic [MSG_W-1:0]    rd_end;
    logic                rd_heard;
    logic                before_j;
    logic [MSG_W-1:0]    room;

    assign o_pop          = (r_state == S_IDLE) & i_valid;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_board = r_board;
    assign o_range_start  = r_start;
    assign o_range_count  = r_rcount;
    assign o_last_result  = r_last;

    // one read address per cycle, chosen by the state
    always_comb begin
        unique case (r_state)
            S_REMOVE: rd_idx = IDX_W'(r_count - 1'b1);
            S_SCAN:   rd_idx = r_j[IDX_W-1:0];
            default:  rd_idx = r_idx[IDX_W-1:0];
        endcase
        rd_id    = r_mid[rd_idx];
        rd_start = r_mstart[rd_idx];
        rd_end   = r_mend[rd_idx];
        rd_heard = r_heard[rd_idx];
        // entry j sorts ahead of entry i: by start, then end, then slot
        before_j = (rd_start < r_si) ||
                   ((rd_start == r_si) &&
                    ((rd_end < r_ei) || ((rd_end == r_ei) && (r_j < r_idx))));
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_count   = r_count;
        n_idx     = r_idx;
        n_j       = r_j;
        n_heard   = r_heard;
        n_found   = r_found;
        n_pend_v  = r_pend_v;
        n_strobe  = 1'b0;
        n_cmd     = r_cmd;
        n_si      = r_si;
        n_ei      = r_ei;
        n_prev    = r_prev;
        n_emax    = r_emax;
        n_best    = r_best;
        n_bstart  = r_bstart;
        n_pend_id = r_pend_id;
        n_status  = r_status;
        n_board   = r_board;
        n_start   = '0;
        n_rcount  = '0;
        n_last    = 1'b1;
        w_en      = 1'b0;
        w_addr    = r_idx[IDX_W-1:0];
        w_id      = rd_id;
        w_start   = rd_start;
        w_end     = rd_end;
        room      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_cmd;
                    n_idx = '0;
                    unique case (i_cmd.op)
                        OPC_HB_START: n_heard = '0;
                        OPC_HB_END: begin
                            n_pend_v = 1'b0;
                            n_state  = S_SWEEP;
                        end
                        default: n_state = S_FIND;
                    endcase
                end
            end

            // linear lookup of the command's board
            S_FIND: begin
                n_board = r_cmd.board;
                if (r_idx == r_count) begin
                    if (r_cmd.op == OPC_JOIN) begin
                        if (r_count == CNT_W'(MAX_MEMBERS)) begin
                            n_strobe = 1'b1;
                            n_status = ST_NO_ROOM;
                            n_state  = S_IDLE;
                        end else begin
                            n_idx   = '0;
                            n_emax  = '0;
                            n_found = 1'b0;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_strobe = 1'b1;
                        n_status = ST_NOT_FOUND;
                        n_state  = S_IDLE;
                    end
                end else if (rd_id == r_cmd.board) begin
                    n_strobe = 1'b1;
                    n_ret    = S_IDLE;
                    unique case (r_cmd.op)
                        OPC_JOIN: begin
                            n_status = ST_EXISTS;
                            n_state  = S_IDLE;
                        end
                        OPC_REPLY: begin
                            if (rd_heard) begin
                                n_status = ST_KICKED;
                                n_state  = S_REMOVE;
                            end else begin
                                n_heard[rd_idx] = 1'b1;
                                n_status        = ST_HEARD;
                                n_state         = S_IDLE;
                            end
                        end
                        default: begin
                            n_status = ST_KICKED;
                            n_state  = S_REMOVE;
                        end
                    endcase
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // last entry moves into the freed slot
            S_REMOVE: begin
                w_en            = 1'b1;
                n_heard[w_addr] = rd_heard;
                n_count         = r_count - 1'b1;
                n_state         = r_ret;
            end

            // heartbeat end: drop silent boards, report one behind
            S_SWEEP: begin
                if (r_idx == r_count) begin
                    if (r_pend_v) begin
                        n_strobe = 1'b1;
                        n_status = ST_KICKED;
                        n_board  = r_pend_id;
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end else if (!rd_heard) begin
                    if (r_pend_v) begin
                        n_strobe = 1'b1;
                        n_status = ST_KICKED;
                        n_board  = r_pend_id;
                        n_last   = 1'b0;
                    end
                    n_pend_v  = 1'b1;
                    n_pend_id = rd_id;
                    n_ret     = S_SWEEP;
                    n_state   = S_REMOVE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // fetch entry i, or judge the gap above the highest end
            S_LOAD: begin
                if (r_idx == r_count) begin
                    if (i_id_space_top >= r_emax) begin
                        room = i_id_space_top - r_emax;
                        if (room >= r_cmd.need && (!r_found || room < r_best)) begin
                            n_found  = 1'b1;
                            n_bstart = r_emax;
                        end
                    end
                    n_state = S_PLACE;
                end else begin
                    n_si    = rd_start;
                    n_ei    = rd_end;
                    n_emax  = (rd_end > r_emax) ? rd_end : r_emax;
                    n_prev  = '0;
                    n_j     = '0;
                    n_state = S_SCAN;
                end
            end

            // highest end among entries sorted ahead of i, then judge gap;
            // equal gaps go to the lower address
            S_SCAN: begin
                if (r_j == r_count) begin
                    if (r_si >= r_prev && r_si <= i_id_space_top) begin
                        room = r_si - r_prev;
                        if (room >= r_cmd.need &&
                            (!r_found || room < r_best ||
                             (room == r_best && r_prev < r_bstart))) begin
                            n_found  = 1'b1;
                            n_best   = room;
                            n_bstart = r_prev;
                        end
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LOAD;
                end else begin
                    if (before_j && rd_end > r_prev) begin
                        n_prev = rd_end;
                    end
                    n_j = r_j + 1'b1;
                end
            end

            // append the new member or refuse
            S_PLACE: begin
                n_strobe = 1'b1;
                n_board  = r_cmd.board;
                if (r_found) begin
                    w_en                  = 1'b1;
                    w_addr                = r_count[IDX_W-1:0];
                    w_id                  = r_cmd.board;
                    w_start               = r_bstart;
                    w_end                 = r_bstart + r_cmd.need;
                    n_heard[w_addr]       = 1'b0;
                    n_count               = r_count + 1'b1;
                    n_status              = ST_OK;
                    n_start               = r_bstart;
                    n_rcount              = r_cmd.need;
                end else begin
                    n_status = ST_NO_ROOM;
                end
                n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_j      <= '0;
            r_heard  <= '0;
            r_found  <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_j      <= n_j;
            r_heard  <= n_heard;
            r_found  <= n_found;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    // payload registers and member table
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_si      <= n_si;
        r_ei      <= n_ei;
        r_prev    <= n_prev;
        r_emax    <= n_emax;
        r_best    <= n_best;
        r_bstart  <= n_bstart;
        r_pend_id <= n_pend_id;
        r_status  <= n_status;
        r_board   <= n_board;
        r_start   <= n_start;
        r_rcount  <= n_rcount;
        r_last    <= n_last;
        if (w_en) begin
            r_mid[w_addr]    <= w_id;
            r_mstart[w_addr] <= w_start;
            r_mend[w_addr]   <= w_end;
        end
    end

endmodule

>>> sv/bus_id_range_allocator.sv
// Bus message ID allocator. Items are taken whenever busy is low into a
// two-entry command queue, so start may be pulsed every cycle until the queue
// fills. The table engine then works one command at a time over a member
// table of n boards, one entry read per cycle. A kick or reply runs a linear
// lookup and may remove the board; a heartbeat end sweeps the table and drops
// silent boards; a heartbeat start clears the heard flags; a join end runs a
// lookup and then a best-fit search over all pairs of entries. Results appear
// on o_strobe for one cycle each and cannot be held off by the receiver.
// depends on bira_pkg, bira_front, bira_queue, bira_back
module bus_id_range_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_opcode,
    input  logic [bira_pkg::BOARD_W-1:0]  i_board_id,
    input  logic [bira_pkg::SIZE_W-1:0]   i_log_size,
    input  logic                          i_last_log,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bira_pkg::MSG_W-1:0]    i_cfg_data,
    output logic                          o_strobe,
    output logic [2:0]                    o_status,
    output logic [bira_pkg::BOARD_W-1:0]  o_result_board,
    output logic [bira_pkg::MSG_W-1:0]    o_range_start,
    output logic [bira_pkg::MSG_W-1:0]    o_range_count,
    output logic                          o_last_result
);
    import bira_pkg::*;

    logic [MSG_W-1:0] r_id_space_top;
    logic             q_full;
    logic             q_push;
    logic             q_valid;
    logic             q_pop;
    t_cmd             f_cmd;
    t_cmd             q_cmd;

    // configuration transfer, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_space_top <= TOP_RESET;
        end else if (i_cfg_valid) begin
            r_id_space_top <= i_cfg_data;
        end
    end

    // front end
    bira_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_board_id (i_board_id),
        .i_log_size (i_log_size),
        .i_last_log (i_last_log),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    // command queue
    bira_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // table engine
    bira_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_id_space_top (r_id_space_top),
        .i_valid        (q_valid),
        .i_cmd          (q_cmd),
        .o_pop          (q_pop),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_result_board (o_result_board),
        .o_range_start  (o_range_start),
        .o_range_count  (o_range_count),
        .o_last_result  (o_last_result)
    );

endmodule
